// ===== rtl/core/edc_pkg.sv =====
// ----------------------------------------------------------------------------
// edc_pkg: shared types and constants of the elevator dispatch controller
// Field widths, operation and car state codes, transaction structs and the
// command and status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package edc_pkg;

    localparam int FLOOR_W  = 4;
    localparam int RIDER_W  = 8;
    localparam int WEIGHT_W = 12;
    localparam int COUNT_W  = 4;
    localparam int SERVED_W = 16;
    localparam int STATE_W  = 3;
    localparam int PLIM_W   = 4;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [PLIM_W-1:0]   PLIM_RESET = 4'd5;
    localparam logic [WEIGHT_W-1:0] WLIM_RESET = 12'd750;

    // register select taken from the word address
    localparam logic REG_PASSENGER = 1'b0;
    localparam logic REG_WEIGHT    = 1'b1;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_SERVICE = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;
    localparam logic [1:0] OP_DEACT   = 2'd3;

    localparam logic [STATE_W-1:0] MODE_OFFLINE = 3'd0;
    localparam logic [STATE_W-1:0] MODE_IDLE    = 3'd1;
    localparam logic [STATE_W-1:0] MODE_LOADING = 3'd2;
    localparam logic [STATE_W-1:0] MODE_UP      = 3'd3;
    localparam logic [STATE_W-1:0] MODE_DOWN    = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FLOOR_W-1:0] floor_number;
        logic [FLOOR_W-1:0] destination_floor;
        logic [RIDER_W-1:0] rider_weight;
    } item_t;

    typedef struct packed {
        logic [STATE_W-1:0]  car_state;
        logic                should_stop;
        logic [COUNT_W-1:0]  unloaded_count;
        logic [COUNT_W-1:0]  loaded_count;
        logic [COUNT_W-1:0]  riders_aboard;
        logic [WEIGHT_W-1:0] load_aboard;
        logic [SERVED_W-1:0] riders_served;
        logic                request_dropped;
    } result_t;

    typedef struct packed {
        logic latch;
        logic enq;
        logic misc;
        logic svc_begin;
        logic prechk;
        logic unl_step;
        logic unl_end;
        logic load_step;
        logic scan_clr;
        logic scan_step;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       svc_ok;
        logic       unl_more;
        logic       load_go;
        logic       scan_last;
    } sts_t;

endpackage

// ===== rtl/core/elevator_dispatch_controller_top.sv =====
// ----------------------------------------------------------------------------
// elevator_dispatch_controller_top: scan-scheduling elevator car controller
// Enqueue, service, start and deactivate transactions against per-floor rider
// queues and an ordered car slot list, with an APB register port for limits.
// ----------------------------------------------------------------------------
// Enqueue, start, deactivate and a refused service pass from decode to result;
// an accepted service steps through pre-check, unload over the riders aboard,
// a boarding loop that waits on the queue memory's registered read port, and a
// scan of the car slots and floors. done is registered from the result emit.
// A new transaction is taken in the cycle that done is shown; results cannot
// be stalled. Reset (rst_n low) empties the car and all queues, sets floor 1,
// offline, and the limits to 5 riders and 750 weight units; no clearing pass.
// ----------------------------------------------------------------------------
module elevator_dispatch_controller_top
#(
    parameter int FLOOR_COUNT = 8,
    parameter int CAR_SLOTS   = 8,
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  edc_pkg::item_t                item,
    output logic                          done,
    output edc_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [edc_pkg::ADDR_W-1:0]    paddr,
    input  logic [edc_pkg::DATA_W-1:0]    pwdata,
    output logic [edc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import edc_pkg::*;

    logic [PLIM_W-1:0]   plim_reg;
    logic [WEIGHT_W-1:0] wlim_reg;
    logic                cfg_wr;
    cmd_t                cmd;
    sts_t                sts;

    // Zero-wait-state APB: write on the access phase, reads are combinational.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plim_reg <= PLIM_RESET;
            wlim_reg <= WLIM_RESET;
        end
        else if (cfg_wr)
        begin
            // word address bit selects the register; byte lanes are ignored
            unique case (paddr[2])
                REG_PASSENGER: plim_reg <= pwdata[PLIM_W-1:0];
                REG_WEIGHT:    wlim_reg <= pwdata[WEIGHT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PASSENGER: prdata = DATA_W'(plim_reg);
            REG_WEIGHT:    prdata = DATA_W'(wlim_reg);
        endcase
    end

    // Sequencer: walks each transaction through its phases.
    edc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath: queues, car slots, scan flags and the result register.
    edc_dpath
    #(
        .FLOOR_COUNT (FLOOR_COUNT),
        .CAR_SLOTS   (CAR_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .item            (item),
        .passenger_limit (plim_reg),
        .weight_limit    (wlim_reg),
        .result          (result),
        .done            (done)
    );

endmodule

// ===== rtl/core/edc_ctrl.sv =====
// ----------------------------------------------------------------------------
// edc_ctrl: transaction sequencer
// Steps each accepted transaction through decode and result phases, with
// pre-check, unload, load, scan and finish phases for an accepted service.
// ----------------------------------------------------------------------------
module edc_ctrl
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  edc_pkg::sts_t sts,
    output edc_pkg::cmd_t cmd,
    output logic         busy
);
    import edc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PRECHK,
        ST_UNLOAD,
        ST_LOAD,
        ST_LOAD_WAIT,
        ST_SCAN,
        ST_FINISH,
        ST_RESULT
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    assign busy = busy_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:      cmd.latch = start;
            ST_DECODE:
            begin
                unique case (sts.opcode)
                    OP_ENQUEUE: cmd.enq = 1'b1;
                    OP_SERVICE: cmd.svc_begin = sts.svc_ok;
                    OP_START:   cmd.misc = 1'b1;
                    OP_DEACT:   cmd.misc = 1'b1;
                endcase
            end
            ST_PRECHK:    cmd.prechk = 1'b1;
            ST_UNLOAD:
            begin
                cmd.unl_step = sts.unl_more;
                cmd.unl_end  = !sts.unl_more;
            end
            ST_LOAD:
            begin
                cmd.load_step = sts.load_go;
                cmd.scan_clr  = !sts.load_go;
            end
            ST_LOAD_WAIT: cmd = '0;
            ST_SCAN:      cmd.scan_step = 1'b1;
            ST_FINISH:    cmd.finish = 1'b1;
            ST_RESULT:    cmd.emit = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DECODE;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_DECODE:
                begin
                    if (sts.opcode == OP_SERVICE && sts.svc_ok)
                        state_reg <= ST_PRECHK;
                    else
                        state_reg <= ST_RESULT;
                end
                ST_PRECHK:    state_reg <= ST_UNLOAD;
                ST_UNLOAD:    state_reg <= sts.unl_more ? ST_UNLOAD : ST_LOAD;
                ST_LOAD:      state_reg <= sts.load_go ? ST_LOAD_WAIT : ST_SCAN;
                ST_LOAD_WAIT: state_reg <= ST_LOAD;
                ST_SCAN:      state_reg <= sts.scan_last ? ST_FINISH : ST_SCAN;
                ST_FINISH:    state_reg <= ST_RESULT;
                ST_RESULT:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/edc_dpath.sv =====
// ----------------------------------------------------------------------------
// edc_dpath: car and floor queue datapath
// Floor queue memory, car slot list, counters, scan flags and the result
// register, all stepped by sequencer commands.
// ----------------------------------------------------------------------------
module edc_dpath
#(
    parameter int FLOOR_COUNT = 8,
    parameter int CAR_SLOTS   = 8,
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  edc_pkg::cmd_t                   cmd,
    output edc_pkg::sts_t                   sts,
    input  edc_pkg::item_t                  item,
    input  logic [edc_pkg::PLIM_W-1:0]      passenger_limit,
    input  logic [edc_pkg::WEIGHT_W-1:0]    weight_limit,
    output edc_pkg::result_t                result,
    output logic                            done
);
    import edc_pkg::*;

    localparam int FIW    = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
    localparam int QPW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW     = $clog2(QUEUE_DEPTH + 1);
    localparam int SIW    = (CAR_SLOTS > 1) ? $clog2(CAR_SLOTS) : 1;
    localparam int RW     = $clog2(CAR_SLOTS + 1);
    localparam int MD     = FLOOR_COUNT * QUEUE_DEPTH;
    localparam int AW     = $clog2(MD);
    localparam int SCAN_N = (FLOOR_COUNT > CAR_SLOTS) ? FLOOR_COUNT : CAR_SLOTS;
    localparam int CW     = $clog2(SCAN_N + 1);
    localparam int FVX    = $clog2(FLOOR_COUNT + 1);
    localparam int FVW    = (FVX > FLOOR_W) ? FVX : FLOOR_W;
    localparam int QEW    = FLOOR_W + RIDER_W;

    logic [QEW-1:0]      qmem [MD];
    logic [QEW-1:0]      qrd_reg;
    logic [QPW-1:0]      head_reg [FLOOR_COUNT];
    logic [FW-1:0]       fill_reg [FLOOR_COUNT];
    logic [FLOOR_W-1:0]  slot_dst_reg [CAR_SLOTS];
    logic [RIDER_W-1:0]  slot_wt_reg [CAR_SLOTS];

    item_t               item_reg;
    logic [RW-1:0]       riders_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [SERVED_W-1:0] served_reg;
    logic [FVW-1:0]      pf_reg;
    logic [STATE_W-1:0]  mode_reg;
    logic                wind_reg;
    logic [CW-1:0]       cnt_reg;
    logic [RW-1:0]       keep_reg;
    logic [RW-1:0]       unl_reg;
    logic [RW-1:0]       ld_reg;
    logic                pre_stop_reg;
    logic                drop_reg;
    logic                s_above_reg;
    logic                s_below_reg;
    logic                first_found_reg;
    logic                first_up_reg;
    logic                q_above_reg;
    logic                q_below_reg;
    logic                best_valid_reg;
    logic [FVW-1:0]      best_gap_reg;
    logic [FVW-1:0]      best_fl_reg;
    result_t             result_reg;
    logic                done_reg;

    logic                fl_ok;
    logic                dst_ok;
    logic [FIW-1:0]      fidx;
    logic [FIW-1:0]      fill_idx;
    logic [FW-1:0]       fill_rd;
    logic [QPW-1:0]      head_rd;
    logic [QPW-1:0]      head_inc;
    logic [FW:0]         tail_sum;
    logic [QPW-1:0]      tail;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    logic [FLOOR_W-1:0]  qhead_dst;
    logic [RIDER_W-1:0]  qhead_wt;
    logic [RW-1:0]       seat;
    logic                head_fits;
    logic [SIW-1:0]      slot_idx;
    logic [FLOOR_W-1:0]  sd;
    logic [RIDER_W-1:0]  sw;
    logic [FVW-1:0]      sdv;
    logic [FVW-1:0]      fv;
    logic [FVW-1:0]      gap;
    logic                enq_ok;
    logic                above;
    logic                below;
    logic [STATE_W-1:0]  mode_fin;

    assign fl_ok  = (item_reg.floor_number != '0) && (32'(item_reg.floor_number) <= FLOOR_COUNT);
    assign dst_ok = (item_reg.destination_floor != '0)
                 && (32'(item_reg.destination_floor) <= FLOOR_COUNT);
    assign fidx   = FIW'(item_reg.floor_number - FLOOR_W'(1));

    // one read port on the per-floor counts: the scan walks floors, else the item floor
    assign fill_idx = cmd.scan_step ? FIW'(cnt_reg) : fidx;
    assign fill_rd  = fill_reg[fill_idx];
    assign head_rd  = head_reg[fidx];
    assign head_inc = (32'(head_rd) + 1 >= QUEUE_DEPTH) ? '0 : QPW'(32'(head_rd) + 1);
    assign tail_sum = (FW + 1)'(head_rd) + (FW + 1)'(fill_rd);
    assign tail     = (32'(tail_sum) >= QUEUE_DEPTH) ? QPW'(32'(tail_sum) - QUEUE_DEPTH)
                                                     : QPW'(tail_sum);
    assign raddr    = AW'(32'(fidx) * QUEUE_DEPTH + 32'(head_rd));
    assign waddr    = AW'(32'(fidx) * QUEUE_DEPTH + 32'(tail));
    assign qhead_dst = qrd_reg[QEW-1:RIDER_W];
    assign qhead_wt  = qrd_reg[RIDER_W-1:0];

    assign seat = (32'(passenger_limit) < CAR_SLOTS) ? RW'(passenger_limit) : RW'(CAR_SLOTS);
    assign head_fits = (fill_rd != '0) && (riders_reg < seat)
                    && (({1'b0, weight_reg} + (WEIGHT_W + 1)'(qhead_wt))
                        <= {1'b0, weight_limit});

    assign slot_idx = SIW'(cnt_reg);
    assign sd       = slot_dst_reg[slot_idx];
    assign sw       = slot_wt_reg[slot_idx];
    assign sdv      = FVW'(sd);
    assign fv       = FVW'(32'(cnt_reg) + 1);
    assign gap      = (fv > pf_reg) ? fv - pf_reg : pf_reg - fv;
    assign enq_ok   = fl_ok && dst_ok && (32'(fill_rd) < QUEUE_DEPTH);

    assign sts.opcode    = item_reg.opcode;
    assign sts.svc_ok    = (mode_reg != MODE_OFFLINE) && fl_ok;
    assign sts.unl_more  = 32'(cnt_reg) < 32'(riders_reg);
    assign sts.load_go   = !wind_reg && head_fits;
    assign sts.scan_last = (cnt_reg == CW'(SCAN_N - 1));

    assign above = s_above_reg || q_above_reg;
    assign below = s_below_reg || q_below_reg;

    always_comb
    begin
        priority if (wind_reg && riders_reg == '0)
            mode_fin = MODE_OFFLINE;
        else if (mode_reg == MODE_UP)
            mode_fin = above ? MODE_UP : (below ? MODE_DOWN : MODE_IDLE);
        else if (mode_reg == MODE_DOWN)
            mode_fin = below ? MODE_DOWN : (above ? MODE_UP : MODE_IDLE);
        else if (first_found_reg)
            mode_fin = first_up_reg ? MODE_UP : MODE_DOWN;
        else if (!best_valid_reg)
            mode_fin = MODE_IDLE;
        else if (best_fl_reg > pf_reg)
            mode_fin = MODE_UP;
        else if (best_fl_reg < pf_reg)
            mode_fin = MODE_DOWN;
        else
            mode_fin = MODE_LOADING;
    end

    // queue memory: registered read of the item floor's head
    always_ff @(posedge clk)
    begin
        if (cmd.enq && enq_ok)
            qmem[waddr] <= {item_reg.destination_floor, item_reg.rider_weight};
        qrd_reg <= qmem[raddr];
    end

    // car slot list: compact on unload, append on boarding
    always_ff @(posedge clk)
    begin
        if (cmd.unl_step && sdv != pf_reg)
        begin
            slot_dst_reg[SIW'(keep_reg)] <= sd;
            slot_wt_reg[SIW'(keep_reg)]  <= sw;
        end
        if (cmd.load_step)
        begin
            slot_dst_reg[SIW'(riders_reg)] <= qhead_dst;
            slot_wt_reg[SIW'(riders_reg)]  <= qhead_wt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            item_reg <= item;
        if (cmd.emit)
        begin
            result_reg.car_state       <= mode_reg;
            result_reg.should_stop     <= pre_stop_reg || (unl_reg != '0);
            result_reg.unloaded_count  <= COUNT_W'(unl_reg);
            result_reg.loaded_count    <= COUNT_W'(ld_reg);
            result_reg.riders_aboard   <= COUNT_W'(riders_reg);
            result_reg.load_aboard     <= weight_reg;
            result_reg.riders_served   <= served_reg;
            result_reg.request_dropped <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FLOOR_COUNT; f++)
            begin
                head_reg[f] <= '0;
                fill_reg[f] <= '0;
            end
            riders_reg      <= '0;
            weight_reg      <= '0;
            served_reg      <= '0;
            pf_reg          <= FVW'(1);
            mode_reg        <= MODE_OFFLINE;
            wind_reg        <= 1'b0;
            cnt_reg         <= '0;
            keep_reg        <= '0;
            unl_reg         <= '0;
            ld_reg          <= '0;
            pre_stop_reg    <= 1'b0;
            drop_reg        <= 1'b0;
            s_above_reg     <= 1'b0;
            s_below_reg     <= 1'b0;
            first_found_reg <= 1'b0;
            first_up_reg    <= 1'b0;
            q_above_reg     <= 1'b0;
            q_below_reg     <= 1'b0;
            best_valid_reg  <= 1'b0;
            best_gap_reg    <= '0;
            best_fl_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.latch)
            begin
                unl_reg      <= '0;
                ld_reg       <= '0;
                pre_stop_reg <= 1'b0;
                drop_reg     <= 1'b0;
            end
            if (cmd.enq)
            begin
                if (enq_ok)
                    fill_reg[fidx] <= FW'(fill_rd + FW'(1));
                else
                    drop_reg <= 1'b1;
            end
            if (cmd.misc)
            begin
                if (item_reg.opcode == OP_START)
                begin
                    if (mode_reg == MODE_OFFLINE)
                    begin
                        mode_reg <= MODE_IDLE;
                        wind_reg <= 1'b0;
                    end
                end
                else if (mode_reg != MODE_OFFLINE)
                    wind_reg <= 1'b1;
            end
            if (cmd.svc_begin)
            begin
                pf_reg   <= FVW'(item_reg.floor_number);
                cnt_reg  <= '0;
                keep_reg <= '0;
            end
            if (cmd.prechk)
                pre_stop_reg <= sts.load_go;
            if (cmd.unl_step)
            begin
                if (sdv == pf_reg)
                begin
                    weight_reg <= weight_reg - WEIGHT_W'(sw);
                    served_reg <= served_reg + SERVED_W'(1);
                    unl_reg    <= unl_reg + RW'(1);
                end
                else
                    keep_reg <= keep_reg + RW'(1);
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.unl_end)
                riders_reg <= keep_reg;
            if (cmd.load_step)
            begin
                riders_reg     <= riders_reg + RW'(1);
                weight_reg     <= weight_reg + WEIGHT_W'(qhead_wt);
                fill_reg[fidx] <= FW'(fill_rd - FW'(1));
                head_reg[fidx] <= head_inc;
                ld_reg         <= ld_reg + RW'(1);
            end
            if (cmd.scan_clr)
            begin
                cnt_reg         <= '0;
                s_above_reg     <= 1'b0;
                s_below_reg     <= 1'b0;
                first_found_reg <= 1'b0;
                first_up_reg    <= 1'b0;
                q_above_reg     <= 1'b0;
                q_below_reg     <= 1'b0;
                best_valid_reg  <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (32'(cnt_reg) < 32'(riders_reg))
                begin
                    if (sdv > pf_reg)
                        s_above_reg <= 1'b1;
                    if (sdv < pf_reg)
                        s_below_reg <= 1'b1;
                    if (!first_found_reg && sdv != pf_reg)
                    begin
                        first_found_reg <= 1'b1;
                        first_up_reg    <= sdv > pf_reg;
                    end
                end
                if (32'(cnt_reg) < FLOOR_COUNT && fill_rd != '0)
                begin
                    if (fv > pf_reg)
                        q_above_reg <= 1'b1;
                    if (fv < pf_reg)
                        q_below_reg <= 1'b1;
                    // strict compare keeps the lower floor on a tie
                    if (!best_valid_reg || gap < best_gap_reg)
                    begin
                        best_valid_reg <= 1'b1;
                        best_gap_reg   <= gap;
                        best_fl_reg    <= fv;
                    end
                end
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                mode_reg <= mode_fin;
                if (wind_reg && riders_reg == '0)
                    wind_reg <= 1'b0;
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/core/edc_checker.sv =====
// ----------------------------------------------------------------------------
// edc_props: port-level checks of the elevator dispatch controller
// Watches the transaction handshake and result strobe over time.
// ----------------------------------------------------------------------------
module edc_props
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input edc_pkg::result_t result
);
    import edc_pkg::*;

    // an accepted transaction holds off further starts
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after acceptance");

    // the result strobe is never shown back to back
    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // result shows as the transaction retires
    a_done_retire: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside transaction retirement");

    // an empty car carries no weight
    a_empty_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.riders_aboard == '0) |-> (result.load_aboard == '0))
        else $error("weight left in an empty car");

    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.car_state <= MODE_DOWN))
        else $error("car state code out of range");

endmodule

bind elevator_dispatch_controller_top edc_props u_edc_props
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
